// ===== src/sine_pcm_byte_generator_core_defines.svh =====
// assertion macros used by the checker file of the sine pcm byte generator
// depends on nothing; take it in with `include
`ifndef SINE_PCM_BYTE_GENERATOR_CORE_DEFINES_SVH
`define SINE_PCM_BYTE_GENERATOR_CORE_DEFINES_SVH

// same-cycle implication, off while reset is high
`define SPBG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while reset is high
`define SPBG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// implication that is checked through reset as well
`define SPBG_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/spbg_pkg.sv =====
// constants, types and helper functions of the sine pcm byte generator
// used by every module of the block but the checker; depends on nothing
package spbg_pkg;

  localparam int PHASE_BITS         = 32;
  localparam int SINE_TABLE_ENTRIES = 1024;
  localparam int MAX_CHANNELS       = 16;
  localparam int MAX_SAMPLE_BYTES   = 4;

  localparam int TABLE_BITS = $clog2(SINE_TABLE_ENTRIES);
  localparam int NUM_BITS   = TABLE_BITS + 1;

  // configuration port
  localparam int CFG_WIDTH      = 32;
  localparam int CFG_INDEX_BITS = 2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_PHASE_INC    = 2'd0,
    CFG_CHANNELS     = 2'd1,
    CFG_SAMPLE_BYTES = 2'd2
  } cfg_reg_t;

  localparam int CHAN_CFG_BITS  = 5;
  localparam int BYTE_CFG_BITS  = 3;
  localparam int CHAN_IDX_BITS  = 4;
  localparam int BYTE_IDX_BITS  = 2;

  localparam logic [CFG_WIDTH-1:0]     PHASE_INC_RESET = 32'd42852281;
  localparam logic [CHAN_CFG_BITS-1:0] CHANNELS_RESET  = 5'd2;
  localparam logic [BYTE_CFG_BITS-1:0] BYTES_RESET     = 3'd2;

  // fixed-point sine
  localparam logic [30:0] HALF_PI_Q30  = 31'd1686629713;
  localparam int          MAG_BITS     = 18;
  localparam logic [MAG_BITS-1:0] ONE_Q17 = 18'd131072;
  localparam int          ROUND_SHIFT  = 13;
  localparam logic [32:0] ROUND_HALF   = 33'd4096;
  localparam int          MAXVAL_BITS  = 30;
  localparam int          SAMPLE_BITS  = 32;

  localparam int TAYLOR_TERMS  = 5;
  localparam int TERM_IDX_BITS = $clog2(TAYLOR_TERMS);

  // divisors (2n)(2n+1) and their reciprocals floor(2^32 / d)
  localparam logic [6:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
    7'd6, 7'd20, 7'd42, 7'd72, 7'd110
  };
  localparam logic [31:0] TAYLOR_RECIP [TAYLOR_TERMS] = '{
    32'((64'd1 << 32) / 64'd6),
    32'((64'd1 << 32) / 64'd20),
    32'((64'd1 << 32) / 64'd42),
    32'((64'd1 << 32) / 64'd72),
    32'((64'd1 << 32) / 64'd110)
  };

  // queue between front and back
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [PHASE_BITS-1:0]    phase;
    logic [CHAN_CFG_BITS-1:0] chans;
    logic [BYTE_CFG_BITS-1:0] nbytes;
  } job_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0]   bits;
    logic [CHAN_CFG_BITS-1:0] chans;
    logic [BYTE_CFG_BITS-1:0] nbytes;
  } sample_t;

  typedef enum logic [3:0] {
    SIN_IDLE,
    SIN_THETA,
    SIN_SQ1,
    SIN_SQ2,
    SIN_RECIP,
    SIN_FIX,
    SIN_ROUND,
    SIN_SCALE,
    SIN_DONE
  } sin_state_t;

  // full scale 2^(8*nbytes-2)-1 for a clamped byte count
  function automatic logic [MAXVAL_BITS-1:0] full_scale(input logic [BYTE_CFG_BITS-1:0] nbytes);
    logic [MAXVAL_BITS-1:0] v;
    case (nbytes)
      3'd1:    v = 30'h3f;
      3'd2:    v = 30'h3fff;
      3'd3:    v = 30'h3fffff;
      default: v = 30'h3fffffff;
    endcase
    return v;
  endfunction

endpackage

// ===== src/spbg_if.sv =====
// valid/ready channel interfaces of the sine pcm byte generator
// tick channel in, byte channel out; depends on nothing
interface spbg_tick_if;
  logic valid;
  logic ready;
  logic frame_tick;

  modport source (output valid, output frame_tick, input ready);
  modport sink (input valid, input frame_tick, output ready);
endinterface

interface spbg_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [3:0] channel_index;
  logic [1:0] byte_index;
  logic       frame_last;

  modport source (output valid, output data_byte, output channel_index,
                  output byte_index, output frame_last, input ready);
  modport sink (input valid, input data_byte, input channel_index,
                input byte_index, input frame_last, output ready);
endinterface

// ===== src/sine_pcm_byte_generator_core.sv =====
// top level of the sine pcm byte generator
// depends on spbg_pkg, spbg_if and the spbg_* modules
//
// usage:
//   ticks: valid/ready channel; each transfer with frame_tick set requests one
//   pcm frame, a transfer with frame_tick clear is taken and dropped.
//   pcm: valid/ready channel of bytes; a frame is channel_count * bytes_per_sample
//   transfers, all bytes of channel 0 first, little-endian, byte 0 sent as zero,
//   frame_last set on the final byte.
//   cfg_wen/cfg_index/cfg_wdata: register write port, index 0 phase increment,
//   1 channel count, 2 bytes per sample; write only while the block is idle.
// timing:
//   the sine unit takes one sample at a time, through 5 taylor terms of 4 steps each
//   plus intake, setup, rounding, scaling and hand-off; bytes of a frame leave one
//   per cycle while the pcm receiver keeps ready high.
//   a 4-deep job queue keeps ticks flowing while the sine unit is busy.
// reset: synchronous, clears the phase to zero and loads the default registers
//   (increment 42852281, 2 channels, 2 bytes). a stalled pcm receiver holds the
//   output byte, then the queue fills and ticks.ready drops.
module sine_pcm_byte_generator_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [spbg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [spbg_pkg::CFG_WIDTH-1:0]      cfg_wdata,
  spbg_tick_if.sink                           ticks,
  spbg_byte_if.source                         pcm
);
  import spbg_pkg::*;

  logic    push_valid;
  job_t    push_data;
  logic    push_ready;
  logic    pop_valid;
  job_t    pop_data;
  logic    pop_ready;
  logic    smp_valid;
  sample_t smp;
  logic    smp_ready;

  spbg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ticks     (ticks),
    .job_valid (push_valid),
    .job       (push_data),
    .job_ready (push_ready)
  );

  spbg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  spbg_sine u_sine (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (pop_valid),
    .job          (pop_data),
    .job_ready    (pop_ready),
    .sample_valid (smp_valid),
    .sample       (smp),
    .sample_ready (smp_ready)
  );

  spbg_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (smp_valid),
    .sample       (smp),
    .sample_ready (smp_ready),
    .pcm          (pcm)
  );

endmodule

// ===== src/spbg_front.sv =====
// front end: configuration registers, tick intake and phase accumulator
// depends on spbg_pkg and spbg_tick_if
module spbg_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wen,
  input  logic [spbg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [spbg_pkg::CFG_WIDTH-1:0]       cfg_wdata,
  spbg_tick_if.sink                            ticks,
  output logic                                 job_valid,
  output spbg_pkg::job_t                       job,
  input  logic                                 job_ready
);
  import spbg_pkg::*;

  logic [CFG_WIDTH-1:0]     phase_inc;
  logic [CHAN_CFG_BITS-1:0] chan_cfg;
  logic [BYTE_CFG_BITS-1:0] byte_cfg;
  logic [PHASE_BITS-1:0]    phase;
  logic [CHAN_CFG_BITS-1:0] chans_clamped;
  logic [BYTE_CFG_BITS-1:0] bytes_clamped;
  logic                     push;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_inc <= PHASE_INC_RESET;
      chan_cfg  <= CHANNELS_RESET;
      byte_cfg  <= BYTES_RESET;
    end else if (cfg_wen) begin
      case (cfg_reg_t'(cfg_index))
        CFG_PHASE_INC:    phase_inc <= cfg_wdata;
        CFG_CHANNELS:     chan_cfg  <= cfg_wdata[CHAN_CFG_BITS-1:0];
        CFG_SAMPLE_BYTES: byte_cfg  <= cfg_wdata[BYTE_CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (chan_cfg == '0)
      chans_clamped = CHAN_CFG_BITS'(1);
    else if (chan_cfg > CHAN_CFG_BITS'(MAX_CHANNELS))
      chans_clamped = CHAN_CFG_BITS'(MAX_CHANNELS);
    else
      chans_clamped = chan_cfg;

    if (byte_cfg == '0)
      bytes_clamped = BYTE_CFG_BITS'(1);
    else if (byte_cfg > BYTE_CFG_BITS'(MAX_SAMPLE_BYTES))
      bytes_clamped = BYTE_CFG_BITS'(MAX_SAMPLE_BYTES);
    else
      bytes_clamped = byte_cfg;
  end

  // ticks with the request bit clear are dropped here
  assign ticks.ready = job_ready;
  assign push        = ticks.valid && job_ready && ticks.frame_tick;
  assign job_valid   = push;
  assign job.phase   = phase;
  assign job.chans   = chans_clamped;
  assign job.nbytes  = bytes_clamped;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (push) begin
      phase <= phase + PHASE_BITS'(phase_inc);
    end
  end

endmodule

// ===== src/spbg_queue.sv =====
// short job queue between the front end and the sine unit
// depends on spbg_pkg
module spbg_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  input  spbg_pkg::job_t push_data,
  output logic           push_ready,
  output logic           pop_valid,
  output spbg_pkg::job_t pop_data,
  input  logic           pop_ready
);
  import spbg_pkg::*;

  job_t                      slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_CNT_BITS-1:0] count;
  logic                      do_push;
  logic                      do_pop;

  assign push_ready = (count != QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QUEUE_PTR_BITS'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QUEUE_PTR_BITS'(1);
      if (do_push && !do_pop)
        count <= count + QUEUE_CNT_BITS'(1);
      else if (do_pop && !do_push)
        count <= count - QUEUE_CNT_BITS'(1);
    end
  end

endmodule

// ===== src/spbg_sine.sv =====
// iterative sine unit: quarter-wave taylor series on one shared multiplier (plus a divisor
// multiply for the quotient fix), then scaling to the sample width; depends on spbg_pkg
module spbg_sine (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  spbg_pkg::job_t    job,
  output logic              job_ready,
  output logic              sample_valid,
  output spbg_pkg::sample_t sample,
  input  logic              sample_ready
);
  import spbg_pkg::*;

  sin_state_t state;
  sin_state_t state_next;

  logic [1:0]               quadrant;
  logic [NUM_BITS-1:0]      num;
  logic [CHAN_CFG_BITS-1:0] chans;
  logic [BYTE_CFG_BITS-1:0] nbytes;
  logic [30:0]              theta;
  logic [31:0]              term;
  logic [31:0]              sum;
  logic [31:0]              quot;
  logic [TERM_IDX_BITS-1:0] n;
  logic [MAG_BITS-1:0]      mag;
  logic [SAMPLE_BITS-1:0]   val;

  logic [TABLE_BITS-1:0]    k;
  logic [TABLE_BITS-1:0]    r;
  logic [NUM_BITS-1:0]      num_in;
  logic [31:0]              mul_a;
  logic [31:0]              mul_b;
  logic [63:0]              prod;
  logic [38:0]              quot_times_div;
  logic [38:0]              rem;
  logic [31:0]              q_fix;
  logic [32:0]              rounded;
  logic [32-ROUND_SHIFT:0]  mag_raw;
  logic                     done_fire;

  // table index, quadrant and distance into the quarter wave
  assign k      = job.phase[PHASE_BITS-1 -: TABLE_BITS];
  assign r      = {k[TABLE_BITS-3:0], 2'b00};
  assign num_in = job.phase[PHASE_BITS-2] ? NUM_BITS'(SINE_TABLE_ENTRIES) - {1'b0, r}
                                          : {1'b0, r};

  always_comb begin
    case (state)
      SIN_THETA: begin
        mul_a = 32'(num);
        mul_b = 32'(HALF_PI_Q30);
      end
      SIN_SQ1, SIN_SQ2: begin
        mul_a = term;
        mul_b = {1'b0, theta};
      end
      SIN_RECIP: begin
        mul_a = term;
        mul_b = TAYLOR_RECIP[n];
      end
      SIN_SCALE: begin
        mul_a = 32'(mag);
        mul_b = 32'(full_scale(nbytes));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  // reciprocal quotient is at most one short
  assign quot_times_div = 39'(quot) * 39'(TAYLOR_DIV[n]);
  assign rem            = 39'(term) - quot_times_div;
  assign q_fix          = (rem >= 39'(TAYLOR_DIV[n])) ? quot + 32'd1 : quot;

  assign rounded = 33'(sum) + ROUND_HALF;
  assign mag_raw = rounded[32:ROUND_SHIFT];

  assign done_fire = (state == SIN_DONE) && (!sample_valid || sample_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIN_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    job_ready  = 1'b0;
    case (state)
      SIN_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) state_next = SIN_THETA;
      end
      SIN_THETA: state_next = SIN_SQ1;
      SIN_SQ1:   state_next = SIN_SQ2;
      SIN_SQ2:   state_next = SIN_RECIP;
      SIN_RECIP: state_next = SIN_FIX;
      SIN_FIX: begin
        if (n == TERM_IDX_BITS'(TAYLOR_TERMS - 1))
          state_next = SIN_ROUND;
        else
          state_next = SIN_SQ1;
      end
      SIN_ROUND: state_next = SIN_SCALE;
      SIN_SCALE: state_next = SIN_DONE;
      SIN_DONE: begin
        if (done_fire) state_next = SIN_IDLE;
      end
      default: state_next = SIN_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      SIN_IDLE: begin
        if (job_valid) begin
          quadrant <= k[TABLE_BITS-1 -: 2];
          num      <= num_in;
          chans    <= job.chans;
          nbytes   <= job.nbytes;
        end
      end
      SIN_THETA: begin
        theta <= 31'(prod >> TABLE_BITS);
        term  <= 32'(prod >> TABLE_BITS);
        sum   <= 32'(prod >> TABLE_BITS);
        n     <= '0;
      end
      SIN_SQ1, SIN_SQ2: term <= 32'(prod >> 30);
      SIN_RECIP:        quot <= 32'(prod >> 32);
      SIN_FIX: begin
        // terms with even n (x^3, x^7, x^11) subtract, clamped at zero; the others add
        if (!n[0])
          sum <= (sum >= q_fix) ? sum - q_fix : '0;
        else
          sum <= sum + q_fix;
        term <= q_fix;
        n    <= n + TERM_IDX_BITS'(1);
      end
      SIN_ROUND: begin
        mag <= (mag_raw > (32-ROUND_SHIFT+1)'(ONE_Q17)) ? ONE_Q17 : MAG_BITS'(mag_raw);
      end
      SIN_SCALE: val <= 32'(prod >> 17);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (done_fire) begin
      sample_valid <= 1'b1;
    end else if (sample_ready) begin
      sample_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      sample.bits   <= quadrant[1] ? (SAMPLE_BITS'(0) - val) : val;
      sample.chans  <= chans;
      sample.nbytes <= nbytes;
    end
  end

endmodule

// ===== src/spbg_emit.sv =====
// byte emitter: walks channels and bytes of one sample into the output register
// depends on spbg_pkg and spbg_byte_if
module spbg_emit (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  input  spbg_pkg::sample_t sample,
  output logic              sample_ready,
  spbg_byte_if.source       pcm
);
  import spbg_pkg::*;

  logic                     active;
  sample_t                  cur;
  logic [CHAN_IDX_BITS-1:0] ch;
  logic [BYTE_IDX_BITS-1:0] bi;
  logic                     issue;
  logic                     last_ch;
  logic                     last_b;
  logic                     load;

  assign issue        = active && (!pcm.valid || pcm.ready);
  assign last_ch      = ({1'b0, ch} == cur.chans - CHAN_CFG_BITS'(1));
  assign last_b       = ({1'b0, bi} == cur.nbytes - BYTE_CFG_BITS'(1));
  assign sample_ready = !active || (issue && last_ch && last_b);
  assign load         = sample_valid && sample_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      pcm.valid <= 1'b0;
    end else begin
      if (issue)
        pcm.valid <= 1'b1;
      else if (pcm.ready)
        pcm.valid <= 1'b0;

      if (load)
        active <= 1'b1;
      else if (issue && last_ch && last_b)
        active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      // the least significant byte always goes out as zero
      pcm.data_byte     <= (bi == '0) ? 8'd0 : 8'(cur.bits >> {bi, 3'b000});
      pcm.channel_index <= ch;
      pcm.byte_index    <= bi;
      pcm.frame_last    <= last_ch && last_b;
    end
    if (load) begin
      cur <= sample;
      ch  <= '0;
      bi  <= '0;
    end else if (issue) begin
      if (last_b) begin
        bi <= '0;
        ch <= last_ch ? '0 : ch + CHAN_IDX_BITS'(1);
      end else begin
        bi <= bi + BYTE_IDX_BITS'(1);
      end
    end
  end

endmodule

// ===== src/spbg_checker.sv =====
// port-level checks of the sine pcm byte generator, bound to the top level
// depends on sine_pcm_byte_generator_core_defines.svh
`include "sine_pcm_byte_generator_core_defines.svh"

module spbg_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] data_byte,
  input logic [3:0] channel_index,
  input logic [1:0] byte_index,
  input logic       frame_last
);

  `SPBG_ASSERT_NEXT(a_valid_held, clk, rst, out_valid && !out_ready, out_valid, "pcm valid dropped while stalled")
  `SPBG_ASSERT_NEXT(a_payload_held, clk, rst, out_valid && !out_ready, $stable({data_byte, channel_index, byte_index, frame_last}), "pcm payload changed while stalled")
  `SPBG_ASSERT_NOW(a_byte0_zero, clk, rst, out_valid && (byte_index == 2'd0), data_byte == 8'd0, "least significant byte not zero")
  `SPBG_ASSERT_ALWAYS(a_reset_idle, clk, $past(rst), !out_valid, "pcm valid after reset")

endmodule

bind sine_pcm_byte_generator_core spbg_checker u_spbg_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (pcm.valid),
  .out_ready     (pcm.ready),
  .data_byte     (pcm.data_byte),
  .channel_index (pcm.channel_index),
  .byte_index    (pcm.byte_index),
  .frame_last    (pcm.frame_last)
);
